// ----- hw/rtl/tkr_pkg.sv -----
// Package for the top-K insertion ranker: list size, index width,
// command codes and the entry record. No dependencies.
`timescale 1ns / 1ps

package tkr_pkg;

    localparam int TOP_K = 20;
    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int RANK_W = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] hits;
        logic [63:0] bytes;
    } entry_t;

endpackage

// ----- hw/rtl/tkr_ifs.sv -----
// Channel interfaces of the top-K insertion ranker: input word, result
// word and mode register write. Depends on nothing but clock-free wires.
`timescale 1ns / 1ps

interface tkr_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] server_addr;
    logic [31:0] hit_count;
    logic [63:0] byte_total;

    modport source (output valid, command, server_addr, hit_count, byte_total,
                    input ready);
    modport sink (input valid, command, server_addr, hit_count, byte_total,
                  output ready);
endinterface

interface tkr_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  rank;
    logic [31:0] ranked_addr;
    logic [31:0] ranked_hits;
    logic [63:0] ranked_bytes;
    logic        last;

    modport source (output valid, rank, ranked_addr, ranked_hits, ranked_bytes, last,
                    input ready);
    modport sink (input valid, rank, ranked_addr, ranked_hits, ranked_bytes, last,
                  output ready);
endinterface

interface tkr_cfg_if;
    logic valid;
    logic ready;
    logic rank_by_bytes;

    modport source (output valid, rank_by_bytes, input ready);
    modport sink (input valid, rank_by_bytes, output ready);
endinterface

// ----- hw/rtl/top_k_insertion_ranker_core.sv -----
// Top-K insertion ranker: a list memory swept by one shared comparator.
// An insert holds the input low after acceptance while it scans the entries up from
// the bottom, and also while it places a new rank 0 entry; a skipped insert frees
// it at once. A dump holds it low while all TOP_K entries go out as the output drains.
// Reset (rst_n, async, active low) clears the list through its valid bits and
// sets hit-count mode. Depends on tkr_pkg and the interfaces of tkr_ifs.sv.
`timescale 1ns / 1ps

module top_k_insertion_ranker_core (
    input  logic       clk,
    input  logic       rst_n,
    tkr_cfg_if.sink    cfg,
    tkr_in_if.sink     in_item,
    tkr_out_if.source  out_item
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    localparam logic [tkr_pkg::IDX_W-1:0] IDX_LAST = tkr_pkg::IDX_W'(tkr_pkg::TOP_K - 1);
    localparam logic [tkr_pkg::IDX_W-1:0] IDX_ZERO = '0;

    // The list lives in a small memory with one write and one read port.
    // A valid bit per entry makes a never-written or dumped entry read as
    // zero, which is the cleared value.
    tkr_pkg::entry_t               mem [tkr_pkg::TOP_K];
    tkr_pkg::entry_t               rd_data_reg;
    logic                          rd_ok_reg;
    logic [tkr_pkg::TOP_K-1:0]     valid_reg, valid_next;

    logic                          rd_en;
    logic [tkr_pkg::IDX_W-1:0]     rd_addr;
    logic                          wr_en;
    logic [tkr_pkg::IDX_W-1:0]     wr_addr;
    tkr_pkg::entry_t               wr_data;

    logic [1:0]                    state_reg, state_next;
    logic [tkr_pkg::IDX_W-1:0]     idx_reg, idx_next;
    tkr_pkg::entry_t               cand_reg, cand_next;
    logic [63:0]                   cand_key_reg, cand_key_next;
    logic                          mode_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [5:0]                    out_rank_reg, out_rank_next;
    tkr_pkg::entry_t               out_ent_reg, out_ent_next;
    logic                          out_last_reg, out_last_next;

    tkr_pkg::entry_t               cur_ent;
    logic [63:0]                   cur_key;
    logic                          in_fire;
    logic                          out_free;

    assign cfg.ready     = 1'b1;
    assign in_item.ready = (state_reg == S_IDLE);
    assign in_fire       = in_item.valid && in_item.ready;
    assign out_free      = !out_valid_reg || out_item.ready;

    assign out_item.valid        = out_valid_reg;
    assign out_item.rank         = out_rank_reg;
    assign out_item.ranked_addr  = out_ent_reg.addr;
    assign out_item.ranked_hits  = out_ent_reg.hits;
    assign out_item.ranked_bytes = out_ent_reg.bytes;
    assign out_item.last         = out_last_reg;

    // The entry under the scan pointer, and its key in the current mode.
    assign cur_ent = rd_ok_reg ? rd_data_reg : '0;
    assign cur_key = mode_reg ? cur_ent.bytes : {32'd0, cur_ent.hits};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cand_next      = cand_reg;
        cand_key_next  = cand_key_reg;
        valid_next     = valid_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = cand_reg;
        out_valid_next = out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_ent_next   = out_ent_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_item.command == tkr_pkg::CMD_DUMP)
                    begin
                        // Dump walks the list from rank 0 downward.
                        idx_next   = IDX_ZERO;
                        rd_en      = 1'b1;
                        rd_addr    = IDX_ZERO;
                        state_next = S_DUMP;
                    end
                    else if (in_item.hit_count != 32'd0)
                    begin
                        // Insert scans upward from the bottom entry.
                        cand_next.addr  = in_item.server_addr;
                        cand_next.hits  = in_item.hit_count;
                        cand_next.bytes = in_item.byte_total;
                        cand_key_next   = mode_reg ? in_item.byte_total
                                                   : {32'd0, in_item.hit_count};
                        idx_next        = IDX_LAST;
                        rd_en           = 1'b1;
                        rd_addr         = IDX_LAST;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // While the entry is below the candidate it moves down one
                // place (the bottom one drops out) and the scan goes on; the
                // first entry that is not below stops it, and the candidate
                // lands just under that entry, or is dropped if that entry is the
                // bottom one. When even rank 0 is below, the candidate is written
                // to rank 0 in S_PUT, since the single write port is taken by
                // moving the old rank 0 entry. The read of the next entry up
                // overlaps the write one place below, so they never collide.
                if (cur_key < cand_key_reg)
                begin
                    if (idx_reg != IDX_LAST)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg + 1'b1;
                        wr_data = cur_ent;
                        valid_next[wr_addr] = 1'b1;
                    end
                    if (idx_reg == IDX_ZERO)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    if (idx_reg != IDX_LAST)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg + 1'b1;
                        wr_data = cand_reg;
                        valid_next[wr_addr] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_PUT:
            begin
                // The candidate outranks every entry and becomes rank 0.
                wr_en      = 1'b1;
                wr_addr    = IDX_ZERO;
                wr_data    = cand_reg;
                valid_next[IDX_ZERO] = 1'b1;
                state_next = S_IDLE;
            end

            S_DUMP:
            begin
                // One word per cycle while the output register drains.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = 6'(idx_reg);
                    out_ent_next   = cur_ent;
                    out_last_next  = (idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST)
                    begin
                        valid_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
            if (cfg.valid && cfg.ready)
            begin
                mode_reg <= cfg.rank_by_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cand_reg     <= cand_next;
        cand_key_reg <= cand_key_next;
        out_rank_reg <= out_rank_next;
        out_ent_reg  <= out_ent_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- test/tb_top_k_insertion_ranker_core.sv -----
// Self-checking testbench for top_k_insertion_ranker_core: a directed table, then random
// insert and dump sequences, with every result word checked against a ranking predictor.
// Depends on tkr_pkg, the channel interfaces of tkr_ifs.sv and the core itself.
`timescale 1ns / 1ps

module tb_top_k_insertion_ranker_core;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 15;
    // An insert holds the core at most for a full scan and a rank 0 write; SCAN_CYCLES adds margin.
    localparam int SCAN_CYCLES  = tkr_pkg::TOP_K + 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_WORDS = 310;

    localparam logic MODE_HITS  = 1'b0;
    localparam logic MODE_BYTES = 1'b1;

    localparam tkr_pkg::entry_t ENTRY_ZERO = '0;
    localparam tkr_pkg::entry_t ENTRY_MAX  = '1;

    // One result word of a dump as the checker expects it.
    typedef struct {
        logic [tkr_pkg::RANK_W-1:0] rank;
        tkr_pkg::entry_t            e;
        logic                       last;
    } dump_word_t;

    typedef enum logic { ROW_WORD, ROW_MODE } row_kind_t;

    // A directed row either sends one input word or writes the mode register. Where
    // has_top is set, the rank 0 word of that dump is typed in rather than predicted.
    typedef struct packed {
        row_kind_t       kind;
        logic            cmd;
        logic            mode;
        tkr_pkg::entry_t cand;
        logic            has_top;
        tkr_pkg::entry_t top;
    } stim_row_t;

    localparam int DIRECTED_N = 24;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // The list starts out cleared, so the first dump reports zeros.
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_HITS, ENTRY_ZERO, 1'b1, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS, ENTRY_MAX,  1'b0, ENTRY_ZERO},
        // A zero hit count is skipped even with the largest byte total.
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS,
          '{32'h0000_0009, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS, '{32'h0000_0001, 32'h1, 64'h0},
          1'b0, ENTRY_ZERO},
        // Equal hit count: the earlier entry stays ahead.
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS, '{32'h0000_0002, 32'hFFFF_FFFF, 64'h5},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS,
          '{32'h0000_0003, 32'h7, 64'h8000_0000_0000_0000}, 1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_HITS, ENTRY_ZERO, 1'b1, ENTRY_MAX},
        // The dump before this one cleared the list; candidate fields of a dump are ignored.
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_HITS,
          '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 64'hDEAD_BEEF_0123_4567}, 1'b1, ENTRY_ZERO},
        '{ROW_MODE, tkr_pkg::CMD_INSERT, MODE_BYTES, ENTRY_ZERO, 1'b0, ENTRY_ZERO},
        // In byte mode a zero byte total never enters a cleared list.
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h10, 32'h5, 64'h0},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h11, 32'h0, 64'h64},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h12, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h13, 32'h2, 64'h1},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h14, 32'h3, 64'hFFFF_FFFF_FFFF_FFFF},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_BYTES, ENTRY_ZERO, 1'b1,
          '{32'h12, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF}},
        // Fill under hit ranking, then switch to bytes without clearing: no re-sort.
        '{ROW_MODE, tkr_pkg::CMD_INSERT, MODE_HITS, ENTRY_ZERO, 1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS, '{32'h20, 32'd100, 64'd1000},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_HITS, '{32'h21, 32'd50, 64'd2000},
          1'b0, ENTRY_ZERO},
        '{ROW_MODE, tkr_pkg::CMD_INSERT, MODE_BYTES, ENTRY_ZERO, 1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h22, 32'd9, 64'd1500},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_INSERT, MODE_BYTES, '{32'h23, 32'd9, 64'd3000},
          1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_BYTES, ENTRY_ZERO, 1'b0, ENTRY_ZERO},
        '{ROW_MODE, tkr_pkg::CMD_INSERT, MODE_HITS, ENTRY_ZERO, 1'b0, ENTRY_ZERO},
        '{ROW_WORD, tkr_pkg::CMD_DUMP,   MODE_HITS, ENTRY_MAX, 1'b1, ENTRY_ZERO}
    };

    logic clk;
    logic rst_n;

    tkr_cfg_if cfg_ch ();
    tkr_in_if  in_ch ();
    tkr_out_if out_ch ();

    top_k_insertion_ranker_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    // Predictor state: its own copy of the ranked list and of the mode register.
    tkr_pkg::entry_t ranking [tkr_pkg::TOP_K];
    logic            by_bytes;
    dump_word_t      dump_q [$];

    int errors;
    int quiet_cycles;
    int hold_req;
    bit idle_on;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // The key that orders the list under the current mode.
    function automatic logic [63:0] rank_key(tkr_pkg::entry_t e);
        return by_bytes ? e.bytes : {32'h0, e.hits};
    endfunction

    // Applies one accepted input word to the predicted list. A dump queues TOP_K
    // expected words and clears the list; an insert scans up from the bottom entry
    // and stops under the first entry whose key is not below the candidate's.
    function automatic void rank_word(logic cmd, tkr_pkg::entry_t cand, logic has_top,
                                      tkr_pkg::entry_t top);
        dump_word_t w;
        int         pos;
        if (cmd == tkr_pkg::CMD_DUMP)
        begin
            for (int i = 0; i < tkr_pkg::TOP_K; i++)
            begin
                w.rank = tkr_pkg::RANK_W'(i);
                w.e    = (has_top && i == 0) ? top : ranking[i];
                w.last = (i == tkr_pkg::TOP_K - 1);
                dump_q.push_back(w);
            end
            for (int i = 0; i < tkr_pkg::TOP_K; i++)
                ranking[i] = '0;
        end
        else if (cand.hits != 0)
        begin
            pos = tkr_pkg::TOP_K - 1;
            while (pos >= 0 && rank_key(ranking[pos]) < rank_key(cand))
                pos--;
            pos++;
            if (pos < tkr_pkg::TOP_K)
            begin
                for (int i = tkr_pkg::TOP_K - 1; i > pos; i--)
                    ranking[i] = ranking[i - 1];
                ranking[pos] = cand;
            end
        end
    endfunction

    // Random candidate: small keys make ties common, zero and all-ones hit the edges.
    function automatic tkr_pkg::entry_t rand_candidate();
        tkr_pkg::entry_t c;
        c.addr = $urandom;
        case ($urandom_range(0, 9))
            0:       c.hits = '0;
            1:       c.hits = '1;
            2, 3, 4: c.hits = $urandom_range(1, 12);
            default: c.hits = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       c.bytes = '0;
            1:       c.bytes = '1;
            2, 3, 4: c.bytes = 64'($urandom_range(0, 12));
            default: c.bytes = {$urandom, $urandom};
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Offers one word after a random gap, if idle_on is set, and holds it until the core takes it.
    // Valid stays high straight into the next word when that word has no gap.
    task automatic send_word(logic cmd, tkr_pkg::entry_t cand, logic has_top,
                             tkr_pkg::entry_t top);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.server_addr <= cand.addr;
        in_ch.hit_count   <= cand.hits;
        in_ch.byte_total  <= cand.bytes;
        do @(posedge clk); while (!in_ch.ready);
        rank_word(cmd, cand, has_top, top);
    endtask

    // Stops sending and waits until every dump word has come back. An insert gives
    // no word, so the last one may still be scanning: allow it a full scan on top.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (dump_q.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    // Mode writes happen only with the core idle.
    task automatic write_mode(logic mode);
        drain();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.rank_by_bytes <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        by_bytes = mode;
    endtask

    // Result side: a random stall before each word, or one long hold-off on request.
    initial
    begin
        int stall;
        forever
        begin
            if (hold_req > 0)
                stall = hold_req;
            else
                stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            hold_req = 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Checker and watchdog. Every accepted result word is matched against the oldest
    // expectation; the watchdog ends the run if no handshake completes for too long.
    always @(posedge clk)
    begin
        dump_word_t want;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL top_k_insertion_ranker_core");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;

            if (out_ch.valid && out_ch.ready)
            begin
                if (dump_q.size() == 0)
                    report_mismatch($sformatf("result word rank %0d with none expected",
                                              out_ch.rank));
                else
                begin
                    want = dump_q.pop_front();
                    check_field("rank", 64'(out_ch.rank), 64'(want.rank));
                    check_field("ranked_addr", 64'(out_ch.ranked_addr), 64'(want.e.addr));
                    check_field("ranked_hits", 64'(out_ch.ranked_hits), 64'(want.e.hits));
                    check_field("ranked_bytes", out_ch.ranked_bytes, want.e.bytes);
                    check_field("last", 64'(out_ch.last), 64'(want.last));
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random sequences of inserts closed by
    // a dump, with mode changes between phases and now and then inside a sequence.
    initial
    begin
        int words_sent;
        int seq;
        int n_ins;

        errors       = 0;
        quiet_cycles = 0;
        hold_req     = 0;
        idle_on      = 1'b1;
        by_bytes     = MODE_HITS;
        for (int i = 0; i < tkr_pkg::TOP_K; i++)
            ranking[i] = '0;

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.command        <= tkr_pkg::CMD_INSERT;
        in_ch.server_addr    <= '0;
        in_ch.hit_count      <= '0;
        in_ch.byte_total     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.rank_by_bytes <= MODE_HITS;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_N; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_MODE)
                write_mode(DIRECTED_ROWS[r].mode);
            else
                send_word(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].cand,
                          DIRECTED_ROWS[r].has_top, DIRECTED_ROWS[r].top);
        end

        // Every word sent counts toward the total, skipped inserts included.
        words_sent = 0;
        seq        = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (seq % 4 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                write_mode(logic'($urandom_range(0, 1)));
            end

            if (seq == 2)
            begin
                // Stall the result side for a long stretch while words keep coming, so
                // the core backs up into its input; then wait for everything to drain.
                drain();
                hold_req = HOLD_CYCLES;
                send_word(tkr_pkg::CMD_DUMP, rand_candidate(), 1'b0, ENTRY_ZERO);
                repeat (5) send_word(tkr_pkg::CMD_INSERT, rand_candidate(), 1'b0, ENTRY_ZERO);
                send_word(tkr_pkg::CMD_DUMP, rand_candidate(), 1'b0, ENTRY_ZERO);
                words_sent += 7;
                drain();
            end

            // Mostly long sequences that fill the list and push entries out the bottom.
            n_ins = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6)
                                                 : $urandom_range(15, 40);
            for (int k = 0; k < n_ins && words_sent < RANDOM_WORDS; k++)
            begin
                if (k == n_ins / 2 && $urandom_range(0, 5) == 0)
                    write_mode(~by_bytes);
                send_word(tkr_pkg::CMD_INSERT, rand_candidate(), 1'b0, ENTRY_ZERO);
                words_sent++;
            end
            send_word(tkr_pkg::CMD_DUMP, rand_candidate(), 1'b0, ENTRY_ZERO);
            words_sent++;
            seq++;
        end

        drain();
        if (errors == 0)
            $display("PASS top_k_insertion_ranker_core");
        else
            $display("FAIL top_k_insertion_ranker_core");
        $finish;
    end

endmodule
